[hw/rtl/lspc_pkg.sv]
// Shared types and constants of the LED strip pattern colour generator.
`default_nettype none
package lspc_pkg;

  localparam int LED_W     = 16;
  localparam int FRAME_W   = 32;
  localparam int COLOUR_W  = 24;
  localparam int PAT_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;
  localparam int VAL_W     = 16;
  localparam int CHAN_W    = 13;

  localparam int HUE_FRAC_BITS_DEF = 24;

  // Divider: dividend wide enough for frame * 42, divisor as wide as the LED count.
  localparam int DIV_DW = 38;
  localparam int DIV_NW = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED   = 2'd2;

  localparam logic [PAT_W-1:0] PAT_CONST   = 8'd0;
  localparam logic [PAT_W-1:0] PAT_DOT     = 8'd1;
  localparam logic [PAT_W-1:0] PAT_SWEEP   = 8'd2;
  localparam logic [PAT_W-1:0] PAT_WORM    = 8'd3;
  localparam logic [PAT_W-1:0] PAT_DIM_A   = 8'd4;
  localparam logic [PAT_W-1:0] PAT_WALL_A  = 8'd5;
  localparam logic [PAT_W-1:0] PAT_WALL_B  = 8'd6;
  localparam logic [PAT_W-1:0] PAT_DIM_B   = 8'd7;
  localparam logic [PAT_W-1:0] PAT_FIESTA  = 8'd8;
  localparam logic [PAT_W-1:0] PAT_DIM_C   = 8'd9;
  localparam logic [PAT_W-1:0] PAT_FAST    = 8'd10;
  localparam logic [PAT_W-1:0] PAT_CHASER  = 8'd12;
  localparam logic [PAT_W-1:0] PAT_UNIFORM = 8'd13;
  localparam logic [PAT_W-1:0] PAT_OFF     = 8'd255;

  localparam logic [COLOUR_W-1:0] COL_WHITE  = 24'hFFFFFF;
  localparam logic [COLOUR_W-1:0] COL_WALL_A = 24'hFF8F8F;
  localparam logic [COLOUR_W-1:0] COL_WALL_B = 24'h0000FF;
  localparam logic [COLOUR_W-1:0] COL_BLACK  = 24'h000000;

  localparam logic [DIV_NW-1:0] WALL_MOD  = 16'd186;
  localparam logic [DIV_NW-1:0] WALL_A_TH = 16'd160;
  localparam logic [DIV_NW-1:0] WALL_B_TH = 16'd130;
  localparam logic [DIV_NW-1:0] FIESTA_DEN = 16'd100;

  // Signed Q4.12 constants.
  localparam logic signed [VAL_W-1:0] Q_ONE    = 16'sd4096;
  localparam logic signed [VAL_W-1:0] Q_TENTH  = 16'sd410;
  localparam logic signed [VAL_W-1:0] Q_FIESTA = 16'sd1638;
  localparam logic signed [VAL_W-1:0] Q_FAST   = 16'sd5325;
  localparam logic signed [VAL_W-1:0] Q_CHASER = 16'sd16384;

  // Result of the early stages that bypasses the colour math.
  typedef struct packed {
    logic                hsv;
    logic [COLOUR_W-1:0] word;
  } pass_t;

endpackage
`default_nettype wire

[hw/rtl/lspc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
`default_nettype none
module lspc_div #(
  parameter int DW     = lspc_pkg::DIV_DW,
  parameter int NW     = lspc_pkg::DIV_NW,
  parameter int SIDE_W = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [DW-1:0]     dividend,
  input  logic [NW-1:0]     divisor,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [DW-1:0]     quotient,
  output logic [NW-1:0]     remainder,
  output logic [SIDE_W-1:0] side_out
);

  logic [DW:0]       vld;
  logic [NW-1:0]     rem  [DW+1];
  logic [DW-1:0]     dnd  [DW+1];
  logic [DW-1:0]     quo  [DW+1];
  logic [NW-1:0]     dsr  [DW+1];
  logic [SIDE_W-1:0] side [DW+1];

  assign vld[0]  = in_vld;
  assign rem[0]  = '0;
  assign dnd[0]  = dividend;
  assign quo[0]  = '0;
  assign dsr[0]  = divisor;
  assign side[0] = side_in;

  for (genvar k = 1; k <= DW; k++) begin : g_stage
    logic [NW:0] trial;
    logic [NW:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem[k-1], dnd[k-1][DW-1]};
      diff  = trial - {1'b0, dsr[k-1]};
      ge    = trial >= {1'b0, dsr[k-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? diff[NW-1:0] : trial[NW-1:0];
        dnd[k]  <= {dnd[k-1][DW-2:0], 1'b0};
        quo[k]  <= {quo[k-1][DW-2:0], ge};
        dsr[k]  <= dsr[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  assign out_vld   = vld[DW];
  assign quotient  = quo[DW];
  assign remainder = rem[DW];
  assign side_out  = side[DW];

endmodule
`default_nettype wire

[hw/rtl/lspc_hsv.sv]
// Six-stage fixed-point HSV to colour word pipeline with output register.
`default_nettype none
module lspc_hsv #(
  parameter int HB = lspc_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic [HB-1:0]                       hue,
  input  logic signed [lspc_pkg::VAL_W-1:0]   sat,
  input  logic signed [lspc_pkg::VAL_W-1:0]   val,
  input  lspc_pkg::pass_t                     pass_in,
  output logic                                out_vld,
  output logic [lspc_pkg::COLOUR_W-1:0]       colour
);
  import lspc_pkg::*;

  localparam int RW = HB + 3;
  localparam logic [RW-1:0] ONE_R = RW'(1) << HB;
  localparam logic [RW-1:0] SIX_R = RW'(6) << HB;
  localparam logic [CHAN_W-1:0] C_ONE = 13'd4096;

  logic [5:0] vld;

  // Stage 1: sector and ramps.
  logic [RW-1:0]       ro_raw, ro;
  logic [2:0]          sector;
  logic [11:0]         frac;
  logic [CHAN_W-1:0]   cr, cg, cb;
  logic [CHAN_W-1:0]   s1_r, s1_g, s1_b;
  logic signed [VAL_W-1:0] s1_sat, s1_val;
  pass_t               s1_pass;

  always_comb begin
    ro_raw = {RW'(hue) << 2} + {RW'(hue) << 1} + ONE_R;
    ro     = (ro_raw >= SIX_R) ? ro_raw - SIX_R : ro_raw;
    sector = ro[RW-1:HB];
    frac   = ro[HB-1 -: 12];
    cr = '0;
    cg = '0;
    cb = '0;
    unique case (sector)
      3'd0: begin cr = C_ONE;                 cg = C_ONE - {1'b0, frac}; end
      3'd1: begin cr = C_ONE;                 cb = {1'b0, frac};         end
      3'd2: begin cr = C_ONE - {1'b0, frac};  cb = C_ONE;                end
      3'd3: begin cb = C_ONE;                 cg = {1'b0, frac};         end
      3'd4: begin cb = C_ONE - {1'b0, frac};  cg = C_ONE;                end
      default: begin cg = C_ONE;              cr = {1'b0, frac};         end
    endcase
  end

  // Stage 2: channel times value.
  logic signed [29:0] s2_pr, s2_pg, s2_pb;
  logic signed [VAL_W-1:0] s2_sat;
  pass_t s2_pass;

  // Stage 3: channel sum and saturation complement.
  logic signed [29:0] s3_pr, s3_pg, s3_pb;
  logic signed [31:0] s3_sum;
  logic signed [VAL_W-1:0] s3_sat;
  logic signed [16:0] s3_satc;
  pass_t s3_pass;

  // Stage 4: products.
  logic signed [49:0] s4_mr, s4_mg, s4_mb, s4_ms;
  pass_t s4_pass;

  // Stage 5: mixes.
  logic signed [49:0] s5_xr, s5_xg, s5_xb;
  pass_t s5_pass;

  function automatic logic [7:0] to_byte(input logic signed [49:0] mix);
    logic [56:0] prod;
    logic [20:0] b;
    prod = {8'd0, mix[48:0]};
    prod = (prod << 8) - prod;
    b    = prod[56:36];
    if (mix[49] || mix == '0) begin
      return 8'd0;
    end
    return (b > 21'd255) ? 8'd255 : b[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r    <= cr;
      s1_g    <= cg;
      s1_b    <= cb;
      s1_sat  <= sat;
      s1_val  <= val;
      s1_pass <= pass_in;

      s2_pr   <= 30'($signed({1'b0, s1_r})) * 30'(s1_val);
      s2_pg   <= 30'($signed({1'b0, s1_g})) * 30'(s1_val);
      s2_pb   <= 30'($signed({1'b0, s1_b})) * 30'(s1_val);
      s2_sat  <= s1_sat;
      s2_pass <= s1_pass;

      s3_pr   <= s2_pr;
      s3_pg   <= s2_pg;
      s3_pb   <= s2_pb;
      s3_sum  <= 32'(s2_pr) + 32'(s2_pg) + 32'(s2_pb);
      s3_sat  <= s2_sat;
      s3_satc <= 17'(Q_ONE) - 17'(s2_sat);
      s3_pass <= s2_pass;

      s4_mr   <= 50'(s3_pr) * 50'(s3_sat);
      s4_mg   <= 50'(s3_pg) * 50'(s3_sat);
      s4_mb   <= 50'(s3_pb) * 50'(s3_sat);
      s4_ms   <= 50'(s3_sum) * 50'(s3_satc);
      s4_pass <= s3_pass;

      s5_xr   <= s4_mr + s4_ms;
      s5_xg   <= s4_mg + s4_ms;
      s5_xb   <= s4_mb + s4_ms;
      s5_pass <= s4_pass;

      colour  <= s5_pass.hsv ? {to_byte(s5_xg), to_byte(s5_xb), to_byte(s5_xr)}
                             : s5_pass.word;
    end
  end

  assign out_vld = vld[5];

endmodule
`default_nettype wire

[hw/rtl/led_strip_pattern_colour_top.sv]
// Top level of the LED strip pattern colour generator.
//
//  channel  | direction | payload
//  s_*      | in        | tdata[15:0] led_index, tdata[47:16] frame_number
//  m_*      | out       | tdata[23:0] colour_word
//  cfg_*    | in        | index 0 pattern_select, 1 led_count, 2 fixed_colour
//
// One transaction is taken every cycle while the output is not stalled.
// Each goes through stage 0, the 38-stage restoring divider that serves
// the modulo patterns and the fiesta frame term, two hue stages and six
// colour stages. A stall on the output holds every stage at once.
// Reset (rst, synchronous) clears all valid bits and restores the registers.
`default_nettype none
module led_strip_pattern_colour_top #(
  parameter int HUE_FRAC_BITS = lspc_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [47:0]                        s_tdata,   // led_index, frame_number
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [lspc_pkg::COLOUR_W-1:0]      m_tdata,   // colour_word
  input  logic                               cfg_we,
  input  logic [lspc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lspc_pkg::CFG_W-1:0]         cfg_data
);
  import lspc_pkg::*;

  localparam int HB = HUE_FRAC_BITS;
  localparam logic [63:0] ONE64 = 64'd1 << HB;
  localparam logic [HB-1:0] ST_1_12   = HB'((ONE64 + 64'd6) / 64'd12);
  localparam logic [HB-1:0] ST_1_48   = HB'((ONE64 + 64'd24) / 64'd48);
  localparam logic [HB-1:0] ST_3_100  = HB'((64'd3 * ONE64 + 64'd50) / 64'd100);
  localparam logic [HB-1:0] ST_1_25   = HB'((ONE64 + 64'd12) / 64'd25);
  localparam logic [HB-1:0] ST_1_200  = HB'((ONE64 + 64'd100) / 64'd200);
  localparam logic [HB-1:0] ST_1_1000 = HB'((ONE64 + 64'd500) / 64'd1000);
  localparam logic [HB-1:0] ST_17_100 = HB'((64'd17 * ONE64 + 64'd50) / 64'd100);
  localparam logic [HB-1:0] ST_1_186  = HB'((ONE64 + 64'd93) / 64'd186);
  localparam logic [HB-1:0] ST_1_500  = HB'((ONE64 + 64'd250) / 64'd500);
  localparam logic [HB-1:0] ST_1_20   = HB'((ONE64 + 64'd10) / 64'd20);
  localparam logic [HB-1:0] ST_1_100  = HB'((ONE64 + 64'd50) / 64'd100);

  logic                en;
  logic [PAT_W-1:0]    pattern_sel;
  logic [LED_W-1:0]    led_count;
  logic [COLOUR_W-1:0] fixed_colour;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_sel  <= PAT_CONST;
      led_count    <= 16'd1;
      fixed_colour <= COL_BLACK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN: pattern_sel  <= cfg_data[PAT_W-1:0];
        REG_COUNT:   led_count    <= cfg_data[LED_W-1:0];
        REG_FIXED:   fixed_colour <= cfg_data[COLOUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 0: choose what the divider works on.
  logic                 s0_vld;
  logic [DIV_DW-1:0]    s0_dnd;
  logic [DIV_NW-1:0]    s0_dsr;
  logic [47:0]          s0_side;
  logic [LED_W-1:0]     in_light;
  logic [FRAME_W-1:0]   in_frame, in_wsum;
  logic [DIV_DW-1:0]    dnd_next;
  logic [DIV_NW-1:0]    dsr_next;

  always_comb begin
    in_light = s_tdata[15:0];
    in_frame = s_tdata[47:16];
    in_wsum  = in_frame + FRAME_W'(in_light);
    dnd_next = DIV_DW'(in_wsum);
    dsr_next = led_count;
    if (pattern_sel == PAT_DOT) begin
      dnd_next = DIV_DW'(in_frame);
    end else if (pattern_sel == PAT_WALL_A || pattern_sel == PAT_WALL_B) begin
      dsr_next = WALL_MOD;
    end else if (pattern_sel == PAT_FIESTA) begin
      dnd_next = (DIV_DW'(in_frame) << 5) + (DIV_DW'(in_frame) << 3)
               + (DIV_DW'(in_frame) << 1);
      dsr_next = FIESTA_DEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_dnd  <= dnd_next;
      s0_dsr  <= dsr_next;
      s0_side <= s_tdata;
    end
  end

  logic                d_vld;
  logic [DIV_DW-1:0]   d_quo;
  logic [DIV_NW-1:0]   d_rem;
  logic [47:0]         d_side;

  lspc_div #(
    .DW     (DIV_DW),
    .NW     (DIV_NW),
    .SIDE_W (48)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (s0_vld),
    .dividend  (s0_dnd),
    .divisor   (s0_dsr),
    .side_in   (s0_side),
    .out_vld   (d_vld),
    .quotient  (d_quo),
    .remainder (d_rem),
    .side_out  (d_side)
  );

  // Stage P1: pattern decode, hue products, dimming ramp.
  logic [LED_W-1:0]    light;
  logic [FRAME_W-1:0]  frame, xsrc;
  logic [7:0]          w8, t4, t7, t9;
  logic [HB-1:0]       step_a, step_b;
  logic                sub_next, use_t_next, use_div_next;
  logic [15:0]         tt_next;
  logic signed [VAL_W-1:0] sat_next, vconst_next;
  pass_t               pass_next;

  always_comb begin
    light = d_side[15:0];
    frame = d_side[47:16];
    w8 = frame[7:0] + light[7:0];
    t4 = 8'd0 - {w8[4:0], 3'b000};
    t7 = 8'd0 - light[7:0] - frame[8:1];
    t9 = light[7:0] - frame[8:1];
    xsrc         = frame;
    step_a       = ST_1_20;
    step_b       = ST_1_100;
    sub_next     = 1'b0;
    use_t_next   = 1'b0;
    use_div_next = 1'b0;
    tt_next      = '0;
    sat_next     = Q_ONE;
    vconst_next  = Q_ONE;
    pass_next    = '{hsv: 1'b1, word: COL_BLACK};
    unique case (pattern_sel)
      PAT_CONST: pass_next = '{hsv: 1'b0, word: fixed_colour};
      PAT_DOT: begin
        pass_next.hsv = 1'b0;
        if (led_count != '0 && light == d_rem) begin
          pass_next.word = COL_WHITE;
        end
      end
      PAT_SWEEP: begin
        step_a = ST_1_12;
        step_b = ST_1_48;
      end
      PAT_WORM: begin
        pass_next.hsv = 1'b0;
        if (led_count != '0 && d_rem == led_count - 16'd1) begin
          pass_next.word = COL_WHITE;
        end
      end
      PAT_DIM_A: begin
        step_a = ST_3_100;
        step_b = ST_1_25;
        sub_next = 1'b1;
        use_t_next = 1'b1;
        use_div_next = 1'b1;
        tt_next = 16'(t4) * 16'd144;
      end
      PAT_WALL_A: begin
        pass_next.hsv = 1'b0;
        if (d_rem > WALL_A_TH) begin
          pass_next.word = COL_WALL_A;
        end
      end
      PAT_WALL_B: begin
        pass_next.hsv = 1'b0;
        if (d_rem > WALL_B_TH) begin
          pass_next.word = COL_WALL_B;
        end
      end
      PAT_DIM_B: begin
        step_a = ST_1_200;
        step_b = ST_1_1000;
        sub_next = 1'b1;
        use_t_next = 1'b1;
        use_div_next = 1'b1;
        tt_next = 16'(t7) * 16'd192;
      end
      PAT_FIESTA: begin
        step_a = ST_1_200;
        step_b = ST_17_100;
        xsrc = d_quo[FRAME_W-1:0];
        vconst_next = Q_FIESTA;
      end
      PAT_DIM_C: begin
        step_a = ST_1_1000;
        step_b = ST_1_1000;
        sub_next = 1'b1;
        use_t_next = 1'b1;
        tt_next = 16'(t9) * 16'd24;
      end
      PAT_FAST: begin
        step_a = ST_1_186;
        step_b = ST_1_1000;
        sub_next = 1'b1;
        sat_next = Q_FAST;
      end
      PAT_CHASER: begin
        step_a = ST_1_500;
        step_b = ST_1_500;
        sat_next = Q_CHASER;
      end
      PAT_UNIFORM: begin
        step_a = '0;
        step_b = ST_1_1000;
      end
      PAT_OFF: pass_next = '{hsv: 1'b0, word: COL_BLACK};
      default: ;
    endcase
  end

  logic                p1_vld, p1_sub, p1_use_t, p1_use_div;
  logic [HB-1:0]       p1_ma, p1_mb;
  logic [15:0]         p1_tt;
  logic signed [VAL_W-1:0] p1_sat, p1_vconst;
  pass_t               p1_pass;

  // Stage P2: hue and value.
  logic                p2_vld;
  logic [HB-1:0]       p2_hue;
  logic signed [VAL_W-1:0] p2_sat, p2_val;
  pass_t               p2_pass;
  logic [31:0]         recip;
  logic [15:0]         tdiv;
  logic signed [VAL_W-1:0] val_next;

  // Division by ten of a ramp below 2^16, by reciprocal.
  always_comb begin
    recip = 32'(p1_tt) * 32'd52429;
    tdiv  = p1_use_div ? 16'(recip[31:19]) : p1_tt;
    val_next = p1_use_t ? $signed(tdiv - 16'(Q_TENTH)) : p1_vconst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= d_vld;
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_ma      <= HB'(light) * step_a;
      p1_mb      <= HB'(xsrc) * step_b;
      p1_sub     <= sub_next;
      p1_use_t   <= use_t_next;
      p1_use_div <= use_div_next;
      p1_tt      <= tt_next;
      p1_sat     <= sat_next;
      p1_vconst  <= vconst_next;
      p1_pass    <= pass_next;

      p2_hue  <= p1_sub ? p1_ma - p1_mb : p1_ma + p1_mb;
      p2_sat  <= p1_sat;
      p2_val  <= val_next;
      p2_pass <= p1_pass;
    end
  end

  lspc_hsv #(
    .HB (HB)
  ) u_hsv (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (p2_vld),
    .hue     (p2_hue),
    .sat     (p2_sat),
    .val     (p2_val),
    .pass_in (p2_pass),
    .out_vld (m_tvalid),
    .colour  (m_tdata)
  );

endmodule
`default_nettype wire

[hw/rtl/lspc_check.sv]
// Port-level checks of the pattern colour generator, bound to its top level.
`default_nettype none
module lspc_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [lspc_pkg::COLOUR_W-1:0]      m_tdata
);

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // A held result stalls the whole pipe, so no new transaction is taken.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  // With nothing waiting at the output the pipe must take input.
  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input refused with empty output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind led_strip_pattern_colour_top lspc_check u_check (.*);
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the LED strip pattern colour generator.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import lspc_pkg::*;

  localparam int LATENCY_WAIT = 60;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HUE_BITS     = 24;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint unsigned HUE_ONE  = 64'd1 << HUE_BITS;
  localparam longint unsigned HUE_MASK = HUE_ONE - 64'd1;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [47:0]          s_tdata;   // led_index, frame_number
  logic                 m_tvalid;
  logic                 m_tready;
  logic [COLOUR_W-1:0]  m_tdata;   // colour_word
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  led_strip_pattern_colour_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the configuration registers.
  logic [PAT_W-1:0]    sh_pattern;
  logic [LED_W-1:0]    sh_count;
  logic [COLOUR_W-1:0] sh_fixed;

  logic [COLOUR_W-1:0] colour_queue[$];
  int                  mismatches;
  int                  cycles;
  int                  send_idle_pct;
  int                  recv_stall_pct;

  typedef struct packed {
    logic [PAT_W-1:0]    pat;
    logic [LED_W-1:0]    cnt;
    logic [COLOUR_W-1:0] fix;
    logic [LED_W-1:0]    led;
    logic [FRAME_W-1:0]  frame;
    logic                known;
    logic [COLOUR_W-1:0] colour;
  } dir_row_t;

  dir_row_t dir_rows [0:26];

  function automatic longint unsigned hue_step(longint unsigned n, longint unsigned d);
    return ((n << HUE_BITS) + d / 2) / d;
  endfunction

  function automatic logic [7:0] mix_to_byte(longint pv, longint sum, longint sat);
    longint mix;
    longint b;
    mix = pv * sat + sum * (longint'(4096) - sat);
    if (mix <= 0) return 8'd0;
    b = (mix * 255) >>> 36;
    return (b > 255) ? 8'hFF : b[7:0];
  endfunction

  function automatic logic [COLOUR_W-1:0] hsv_colour(longint unsigned hue, longint sat,
                                                     longint val);
    longint unsigned h;
    longint unsigned ro;
    longint unsigned sector;
    longint f;
    longint r;
    longint g;
    longint b;
    longint sum;
    h = hue & HUE_MASK;
    ro = (h * 6 + HUE_ONE) % (6 * HUE_ONE);
    sector = ro >> HUE_BITS;
    f = longint'((ro & HUE_MASK) >> (HUE_BITS - 12));
    r = 0; g = 0; b = 0;
    case (sector)
      0: begin r = 4096; g = 4096 - f; end
      1: begin r = 4096; b = f; end
      2: begin r = 4096 - f; b = 4096; end
      3: begin b = 4096; g = f; end
      4: begin b = 4096 - f; g = 4096; end
      default: begin g = 4096; r = f; end
    endcase
    r = r * val; g = g * val; b = b * val;
    sum = r + g + b;
    return {mix_to_byte(g, sum, sat), mix_to_byte(b, sum, sat), mix_to_byte(r, sum, sat)};
  endfunction

  function automatic logic [COLOUR_W-1:0] pattern_colour(logic [LED_W-1:0] led,
                                                         logic [FRAME_W-1:0] frame);
    longint unsigned li;
    longint unsigned fr;
    logic [31:0] wsum;
    logic [7:0]  t;
    li = longint'(led);
    fr = longint'(frame);
    wsum = frame + 32'(led);
    case (sh_pattern)
      PAT_CONST: return sh_fixed;
      PAT_DOT:
        return (sh_count != 0 && 32'(led) == frame % 32'(sh_count)) ? COL_WHITE : COL_BLACK;
      PAT_SWEEP:
        return hsv_colour(li * hue_step(1, 12) + fr * hue_step(1, 48), 4096, 4096);
      PAT_WORM:
        return (sh_count != 0 && wsum % 32'(sh_count) == 32'(sh_count) - 1) ?
               COL_WHITE : COL_BLACK;
      PAT_DIM_A: begin
        t = 8'(32'd0 - 32'd8 * wsum);
        return hsv_colour(li * hue_step(3, 100) - fr * hue_step(1, 25), 4096,
                          longint'((int'(t) * 144) / 10) - 410);
      end
      PAT_WALL_A: return (wsum % 186 > 160) ? COL_WALL_A : COL_BLACK;
      PAT_WALL_B: return (wsum % 186 > 130) ? COL_WALL_B : COL_BLACK;
      PAT_DIM_B: begin
        t = 8'(32'd0 - 32'(led) - (frame >> 1));
        return hsv_colour(li * hue_step(1, 200) - fr * hue_step(1, 1000), 4096,
                          longint'((int'(t) * 192) / 10) - 410);
      end
      PAT_FIESTA:
        return hsv_colour(li * hue_step(1, 200) + ((fr * 42) / 100) * hue_step(17, 100),
                          4096, 1638);
      PAT_DIM_C: begin
        t = 8'(32'(led) - (frame >> 1));
        return hsv_colour(li * hue_step(1, 1000) - fr * hue_step(1, 1000), 4096,
                          longint'(int'(t) * 24) - 410);
      end
      PAT_FAST:
        return hsv_colour(li * hue_step(1, 186) - fr * hue_step(1, 1000), 5325, 4096);
      PAT_CHASER:
        return hsv_colour(li * hue_step(1, 500) + fr * hue_step(1, 500), 16384, 4096);
      PAT_UNIFORM: return hsv_colour(fr * hue_step(1, 1000), 4096, 4096);
      PAT_OFF: return COL_BLACK;
      default:
        return hsv_colour(li * hue_step(1, 20) + fr * hue_step(1, 100), 4096, 4096);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** led_strip_pattern_colour_top: FAILED **");
      $finish;
    end
  end

  // Output checker: each result transaction is matched with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (colour_queue.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected colour word %h", m_tdata);
      end else begin
        if (m_tdata !== colour_queue[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("colour_word mismatch: expected %h, got %h", colour_queue[0], m_tdata);
        end
        colour_queue.pop_front();
      end
    end
  end

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (colour_queue.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PATTERN: sh_pattern = value[PAT_W-1:0];
      REG_COUNT:   sh_count   = value[LED_W-1:0];
      REG_FIXED:   sh_fixed   = value[COLOUR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_item(logic [LED_W-1:0] led, logic [FRAME_W-1:0] frame,
                           logic known, logic [COLOUR_W-1:0] colour);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {frame, led};
    do @(posedge clk); while (!s_tready);
    colour_queue.push_back(known ? colour : pattern_colour(led, frame));
  endtask

  task automatic apply_config(logic [PAT_W-1:0] pat, logic [LED_W-1:0] cnt,
                              logic [COLOUR_W-1:0] fix);
    if (pat != sh_pattern) cfg_write(REG_PATTERN, CFG_W'(pat));
    if (cnt != sh_count)   cfg_write(REG_COUNT, CFG_W'(cnt));
    if (fix != sh_fixed)   cfg_write(REG_FIXED, fix);
  endtask

  initial begin
    logic [PAT_W-1:0]    pat;
    logic [LED_W-1:0]    cnt;
    logic [LED_W-1:0]    led;
    logic [FRAME_W-1:0]  frame;
    int                  pick;
    dir_row_t            row;

    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    mismatches = 0; cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    sh_pattern = PAT_CONST; sh_count = 16'd1; sh_fixed = '0;

    dir_rows = '{
      '{PAT_CONST, 16'd1, 24'h000000, 16'd0, 32'd0, 1'b1, COL_BLACK},
      '{PAT_CONST, 16'd1, 24'hFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 24'hFFFFFF},
      '{PAT_CONST, 16'd1, 24'hA5C31E, 16'd5, 32'd7, 1'b1, 24'hA5C31E},
      '{PAT_DOT, 16'd10, 24'h0, 16'd3, 32'd13, 1'b1, COL_WHITE},
      '{PAT_DOT, 16'd10, 24'h0, 16'd4, 32'd13, 1'b1, COL_BLACK},
      '{PAT_DOT, 16'd5, 24'h0, 16'd100, 32'd0, 1'b1, COL_BLACK},
      '{PAT_DOT, 16'd0, 24'h0, 16'd0, 32'd0, 1'b1, COL_BLACK},
      '{PAT_WORM, 16'd0, 24'h0, 16'd0, 32'd0, 1'b1, COL_BLACK},
      '{PAT_WORM, 16'd1, 24'h0, 16'd1234, 32'd99, 1'b1, COL_WHITE},
      '{PAT_WORM, 16'd8, 24'h0, 16'd2, 32'd5, 1'b1, COL_WHITE},
      '{PAT_WORM, 16'd8, 24'h0, 16'd2, 32'd4, 1'b1, COL_BLACK},
      '{PAT_WORM, 16'hFFFF, 24'h0, 16'hFFFF, 32'hFFFFFFFF, 1'b1, COL_WHITE},
      '{PAT_WALL_A, 16'hFFFF, 24'h0, 16'd161, 32'd0, 1'b1, COL_WALL_A},
      '{PAT_WALL_A, 16'hFFFF, 24'h0, 16'd160, 32'd0, 1'b1, COL_BLACK},
      '{PAT_WALL_B, 16'hFFFF, 24'h0, 16'd131, 32'd0, 1'b1, COL_WALL_B},
      '{PAT_OFF, 16'hFFFF, 24'h0, 16'd77, 32'd9, 1'b1, COL_BLACK},
      '{PAT_SWEEP, 16'hFFFF, 24'h0, 16'hFFFF, 32'hFFFFFFFF, 1'b0, COL_BLACK},
      '{PAT_DIM_A, 16'hFFFF, 24'h0, 16'd0, 32'd0, 1'b0, COL_BLACK},
      '{PAT_DIM_A, 16'hFFFF, 24'h0, 16'd31, 32'd0, 1'b0, COL_BLACK},
      '{PAT_DIM_B, 16'hFFFF, 24'h0, 16'hFFFF, 32'd1, 1'b0, COL_BLACK},
      '{PAT_FIESTA, 16'hFFFF, 24'h0, 16'd12, 32'hFFFFFFFF, 1'b0, COL_BLACK},
      '{PAT_DIM_C, 16'hFFFF, 24'h0, 16'd0, 32'd2, 1'b0, COL_BLACK},
      '{PAT_FAST, 16'hFFFF, 24'h0, 16'd500, 32'd1000, 1'b0, COL_BLACK},
      '{PAT_CHASER, 16'hFFFF, 24'h0, 16'd250, 32'd3, 1'b0, COL_BLACK},
      '{PAT_UNIFORM, 16'hFFFF, 24'h0, 16'hFFFF, 32'h80000000, 1'b0, COL_BLACK},
      '{8'd11, 16'hFFFF, 24'h0, 16'd7, 32'd55, 1'b0, COL_BLACK},
      '{8'd200, 16'hFFFF, 24'h0, 16'd40000, 32'd123456, 1'b0, COL_BLACK}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      apply_config(row.pat, row.cnt, row.fix);
      send_item(row.led, row.frame, row.known, row.colour);
    end

    // A write to an index past the register list must leave everything unchanged.
    cfg_write(REG_UNUSED, 24'(PAT_DOT));

    for (int phase = 0; phase < 24; phase++) begin
      pick = $urandom_range(5);
      case (pick)
        0: pat = PAT_OFF;
        1: pat = 8'($urandom_range(255));
        default: pat = 8'($urandom_range(13));
      endcase
      pick = $urandom_range(5);
      case (pick)
        0: cnt = 16'd0;
        1: cnt = 16'd1;
        2: cnt = 16'hFFFF;
        3: cnt = 16'($urandom);
        default: cnt = 16'($urandom_range(40, 2));
      endcase
      wait_drained();
      cfg_write(REG_PATTERN, CFG_W'(pat));
      cfg_write(REG_COUNT, CFG_W'(cnt));
      cfg_write(REG_FIXED, 24'($urandom));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int n = 0; n < 50; n++) begin
        if (phase == 5 && n == 25) begin
          s_tvalid <= 1'b0;
          while (colour_queue.size() != 0) @(posedge clk);
        end
        if ($urandom_range(3) == 0) begin
          led   = 16'($urandom);
          frame = $urandom;
        end else begin
          led   = 16'($urandom_range(int'(cnt) + 4));
          frame = ($urandom_range(1) == 0) ? 32'($urandom_range(2000)) : $urandom;
        end
        send_item(led, frame, 1'b0, COL_BLACK);
      end
    end

    s_tvalid <= 1'b0;
    while (colour_queue.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("** led_strip_pattern_colour_top: PASSED **");
    end else begin
      $display("** led_strip_pattern_colour_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
